@@ design/perlin_noise_3d_core_macros.svh @@
// Assertion macros shared by the noise core files.
`ifndef PERLIN_NOISE_3D_CORE_MACROS_SVH
`define PERLIN_NOISE_3D_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: label");
`define PN_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("%m: label");
`else
`define PN_ASSERT(label, clk, rst, prop)
`define PN_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ design/pn3d_pkg.sv @@
// Package: constants, types and helpers of the 3D noise core.
`timescale 1ns / 1ps
package pn3d_pkg;
  localparam int TableSize = 256;
  localparam int IdxW = $clog2(TableSize);
  localparam int FracBits = 16;
  localparam int One = 1 << FracBits;
  localparam int ValW = FracBits + 4;   // signed working values
  localparam int MulW = 48;
  localparam int MulOpW = 24;           // multiplier operand width

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FADE, ST_HASH, ST_GRAD, ST_LERP, ST_OUT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [31:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic [15:0] noise_value;
  } out_item_t;

  typedef struct packed {
    logic                   start;
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } mul_req_t;

  function automatic logic signed [ValW-1:0] grad(input logic [3:0] h,
      input logic signed [ValW-1:0] x, input logic signed [ValW-1:0] y,
      input logic signed [ValW-1:0] z);
    logic signed [ValW-1:0] a, b;
    a = (h < 4'd8) ? x : y;
    b = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction
endpackage

@@ design/pn3d_if.sv @@
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface pn3d_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pn3d_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pn3d_ram #(parameter int Width = 8, parameter int Depth = 256) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ design/pn3d_mul.sv @@
// Shared signed 24x24 multiplier; operands and product are registered.
`timescale 1ns / 1ps
`include "perlin_noise_3d_core_macros.svh"
module pn3d_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  pn3d_pkg::mul_req_t            req,
  output logic                          done,
  output logic signed [pn3d_pkg::MulW-1:0] prod
);
  // every operand the sequencer issues fits 24 bits signed
  logic signed [pn3d_pkg::MulOpW-1:0] a_r, b_r;
  logic signed [pn3d_pkg::MulW-1:0] p_r;
  logic st1;
  always_ff @(posedge clk) begin
    if (rst) begin
      st1 <= 1'b0;
      done <= 1'b0;
    end else begin
      st1 <= req.start;
      done <= st1;
    end
    if (req.start) begin
      a_r <= req.a[pn3d_pkg::MulOpW-1:0];
      b_r <= req.b[pn3d_pkg::MulOpW-1:0];
    end
    if (st1) begin
      p_r <= a_r * b_r;
    end
  end
  assign prod = p_r;
  `PN_ASSERT(a_done_follows, clk, rst, st1 |=> done)
  `PN_ASSERT(a_start_pipe, clk, rst, req.start |=> st1)
  `PN_ASSERT(a_no_overlap, clk, rst, req.start |-> !st1)
endmodule

@@ design/perlin_noise_3d_core.sv @@
// Top level of the 3D gradient noise core with its sequencer.
`timescale 1ns / 1ps
`include "perlin_noise_3d_core_macros.svh"
// Improved 3D Perlin noise, Q16.16 in, unsigned Q0.16 out. A load item
// writes one permutation byte and gives no result. An evaluate item runs
// a sequencer around one shared two-stage 24x24 multiplier and one
// single-port table RAM: 9 multiplies for the three fades, 14 chained
// table reads, the eight gradient dot products, 7 lerp multiplies and a
// final step to load the result register. With the output side ready,
// the next item can transfer in the cycle in which the result becomes
// valid. The result register parts input from output: a new item is
// taken while a result waits, and a finished evaluate holds in its last
// state until the register is free. Table entries read before they are
// loaded give undefined noise.
module perlin_noise_3d_core (
  input logic clk,
  input logic rst,
  pn3d_if.sink   in_ch,
  pn3d_if.source out_ch
);
  localparam int VW = pn3d_pkg::ValW;
  localparam int MW = pn3d_pkg::MulW;
  localparam int IW = pn3d_pkg::IdxW;

  pn3d_pkg::state_t state, state_next;
  logic [4:0] step, step_next;
  logic [IW-1:0] cx, cy, cz;
  logic [VW-1:0] fx, fy, fz;          // fractions, non-negative
  logic signed [VW-1:0] u, v, w;
  logic signed [MW-1:0] acc;          // 6t^2, then q
  logic signed [MW-1:0] sq;           // t^2, then t^3
  logic [IW-1:0] a_h, b_h, aa, ab, ba, bb;
  logic [3:0] hv [8];
  logic signed [VW-1:0] g [8];
  logic signed [VW-1:0] l [6];
  logic wait_mul, wait_ram;
  logic [15:0] res;
  logic [15:0] noise_hold;
  logic res_valid;
  logic out_load;

  pn3d_pkg::mul_req_t mreq;
  logic mdone;
  logic signed [MW-1:0] mprod;
  pn3d_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(mprod));

  logic ram_we;
  logic [IW-1:0] ram_addr;
  logic [7:0] ram_q;
  pn3d_ram #(.Width(8), .Depth(pn3d_pkg::TableSize)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_ch.data.table_value), .rdata(ram_q));

  logic accept;
  assign in_ch.ready = (state == pn3d_pkg::ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = res_valid;
  assign out_ch.data.noise_value = res;
  // result register free this cycle: empty, or its transfer happens now
  assign out_load = (state == pn3d_pkg::ST_OUT) && (!res_valid || out_ch.ready);

  // Current fade fraction and phase: three multiplies per coordinate.
  logic [1:0] fsel;
  logic [VW-1:0] ft;
  logic [2:0] fph;
  always_comb begin
    case (step)
      5'd0: begin fsel = 2'd0; fph = 3'd0; end
      5'd1: begin fsel = 2'd0; fph = 3'd1; end
      5'd2: begin fsel = 2'd0; fph = 3'd2; end
      5'd3: begin fsel = 2'd1; fph = 3'd0; end
      5'd4: begin fsel = 2'd1; fph = 3'd1; end
      5'd5: begin fsel = 2'd1; fph = 3'd2; end
      5'd6: begin fsel = 2'd2; fph = 3'd0; end
      5'd7: begin fsel = 2'd2; fph = 3'd1; end
      default: begin fsel = 2'd2; fph = 3'd2; end
    endcase
  end
  always_comb begin
    case (fsel)
      2'd0: ft = fx;
      2'd1: ft = fy;
      default: ft = fz;
    endcase
  end

  // Hash read address per step.
  logic [IW-1:0] haddr;
  always_comb begin
    case (step)
      5'd0: haddr = cx;
      5'd1: haddr = cx + 1'b1;
      5'd2: haddr = a_h;
      5'd3: haddr = a_h + 1'b1;
      5'd4: haddr = b_h;
      5'd5: haddr = b_h + 1'b1;
      5'd6: haddr = aa;
      5'd7: haddr = ba;
      5'd8: haddr = ab;
      5'd9: haddr = bb;
      5'd10: haddr = aa + 1'b1;
      5'd11: haddr = ba + 1'b1;
      5'd12: haddr = ab + 1'b1;
      default: haddr = bb + 1'b1;
    endcase
  end

  // Lerp operands: steps 0..3 level 1, 4..5 in v, 6 in w.
  logic signed [VW-1:0] la, lb, lf;
  always_comb begin
    case (step)
      5'd0: begin la = g[0]; lb = g[1]; lf = u; end
      5'd1: begin la = g[2]; lb = g[3]; lf = u; end
      5'd2: begin la = g[4]; lb = g[5]; lf = u; end
      5'd3: begin la = g[6]; lb = g[7]; lf = u; end
      5'd4: begin la = l[0]; lb = l[1]; lf = v; end
      5'd5: begin la = l[2]; lb = l[3]; lf = v; end
      default: begin la = l[4]; lb = l[5]; lf = w; end
    endcase
  end

  // q = 10 + 6t^2 - 15t, with acc still holding 6t^2 from phase 0
  logic signed [MW-1:0] fade_q;
  assign fade_q = MW'(10 * pn3d_pkg::One) + (acc >>> pn3d_pkg::FracBits)
                  - MW'($signed({1'b0, ft}) * 15);

  always_comb begin
    state_next = state;
    step_next = step;
    mreq = '0;
    ram_we = 1'b0;
    ram_addr = in_ch.data.table_index;
    case (state)
      pn3d_pkg::ST_IDLE: begin
        if (accept) begin
          ram_we = (in_ch.data.kind == pn3d_pkg::KIND_LOAD);
          if (in_ch.data.kind == pn3d_pkg::KIND_EVAL) begin
            state_next = pn3d_pkg::ST_FADE;
            step_next = '0;
          end
        end
      end
      pn3d_pkg::ST_FADE: begin
        // phase 0: t*t, phase 1: floor(t^2)*t, phase 2: t^3*q
        if (!wait_mul) begin
          mreq.start = 1'b1;
          mreq.a = MW'($signed({1'b0, ft}));
          mreq.b = MW'($signed({1'b0, ft}));
          if (fph == 3'd1) begin
            mreq.b = sq >>> pn3d_pkg::FracBits;
          end else if (fph == 3'd2) begin
            mreq.a = acc;
            mreq.b = sq;
          end
        end else if (mdone) begin
          step_next = step + 1'b1;
          if (step == 5'd8) begin
            state_next = pn3d_pkg::ST_HASH;
            step_next = '0;
          end
        end
      end
      pn3d_pkg::ST_HASH: begin
        ram_addr = haddr;
        if (wait_ram) begin
          step_next = step + 1'b1;
          if (step == 5'd13) begin
            state_next = pn3d_pkg::ST_GRAD;
            step_next = '0;
          end
        end
      end
      pn3d_pkg::ST_GRAD: begin
        state_next = pn3d_pkg::ST_LERP;
      end
      pn3d_pkg::ST_LERP: begin
        if (!wait_mul) begin
          mreq.start = 1'b1;
          mreq.a = MW'(lf);
          mreq.b = MW'(lb) - MW'(la);
        end else if (mdone) begin
          step_next = step + 1'b1;
          if (step == 5'd6) state_next = pn3d_pkg::ST_OUT;
        end
      end
      pn3d_pkg::ST_OUT: begin
        if (out_load) state_next = pn3d_pkg::ST_IDLE;
      end
      default: state_next = pn3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pn3d_pkg::ST_IDLE;
      step <= '0;
      wait_mul <= 1'b0;
      wait_ram <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      if (mreq.start) wait_mul <= 1'b1;
      else if (mdone) wait_mul <= 1'b0;
      wait_ram <= (state == pn3d_pkg::ST_HASH) && !wait_ram;
      if (out_load) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
    end
  end

  logic signed [VW-1:0] lres;
  assign lres = VW'(la + VW'(mprod >>> pn3d_pkg::FracBits));

  always_ff @(posedge clk) begin
    if (accept) begin
      // floor cell = arithmetic shift, mod table size = low bits
      cx <= in_ch.data.x_coord[pn3d_pkg::FracBits +: IW];
      cy <= in_ch.data.y_coord[pn3d_pkg::FracBits +: IW];
      cz <= in_ch.data.z_coord[pn3d_pkg::FracBits +: IW];
      fx <= VW'(in_ch.data.x_coord[pn3d_pkg::FracBits-1:0]);
      fy <= VW'(in_ch.data.y_coord[pn3d_pkg::FracBits-1:0]);
      fz <= VW'(in_ch.data.z_coord[pn3d_pkg::FracBits-1:0]);
    end
    if (state == pn3d_pkg::ST_FADE && mdone) begin
      case (fph)
        3'd0: begin sq <= mprod; acc <= mprod * 6; end
        3'd1: begin acc <= fade_q; sq <= mprod >>> pn3d_pkg::FracBits; end
        default: begin
          case (fsel)
            2'd0: u <= VW'(mprod >>> pn3d_pkg::FracBits);
            2'd1: v <= VW'(mprod >>> pn3d_pkg::FracBits);
            default: w <= VW'(mprod >>> pn3d_pkg::FracBits);
          endcase
        end
      endcase
    end
    if (state == pn3d_pkg::ST_HASH && wait_ram) begin
      case (step)
        5'd0: a_h <= ram_q + cy;
        5'd1: b_h <= ram_q + cy;
        5'd2: aa <= ram_q + cz;
        5'd3: ab <= ram_q + cz;
        5'd4: ba <= ram_q + cz;
        5'd5: bb <= ram_q + cz;
        default: hv[3'(step - 5'd6)] <= ram_q[3:0];
      endcase
    end
    if (state == pn3d_pkg::ST_GRAD) begin
      for (int i = 0; i < 8; i++) begin
        g[i] <= pn3d_pkg::grad(hv[i],
          $signed(fx) - (i[0] ? VW'(pn3d_pkg::One) : VW'(0)),
          $signed(fy) - (i[1] ? VW'(pn3d_pkg::One) : VW'(0)),
          $signed(fz) - (i[2] ? VW'(pn3d_pkg::One) : VW'(0)));
      end
    end
    if (state == pn3d_pkg::ST_LERP && wait_mul && mdone) begin
      if (step == 5'd6) begin
        if (lres + VW'(pn3d_pkg::One) < 0) noise_hold <= '0;
        else if (lres >= VW'(pn3d_pkg::One)) noise_hold <= 16'hFFFF;
        else noise_hold <= 16'((lres + VW'(pn3d_pkg::One)) >>> (pn3d_pkg::FracBits - 15));
      end else begin
        l[3'(step)] <= lres;
      end
    end
    if (out_load) res <= noise_hold;
  end

  `PN_ASSERT(a_ready_idle, clk, rst, in_ch.ready |-> state == pn3d_pkg::ST_IDLE)
  `PN_ASSERT(a_out_hold, clk, rst, (res_valid && !out_ch.ready) |=> res_valid)
  `PN_ASSERT(a_out_wait, clk, rst, (state == pn3d_pkg::ST_OUT && res_valid && !out_ch.ready) |=> state == pn3d_pkg::ST_OUT)
  `PN_ASSERT(a_out_after_run, clk, rst, $rose(res_valid) |-> $past(state) == pn3d_pkg::ST_OUT)
endmodule
